[sv/lvmm_pkg.sv]
// Shared types, constants and float helper functions for the luminance statistics block.
`timescale 1ns / 1ps
`default_nettype none

package lvmm_pkg;

    // Reset values of the weight registers (float32 bits)
    localparam logic [31:0] RED_WEIGHT_RST   = 32'h3E8A3D71;
    localparam logic [31:0] GREEN_WEIGHT_RST = 32'h3F2B851F;
    localparam logic [31:0] BLUE_WEIGHT_RST  = 32'h3D75C28F;

    localparam logic [31:0] POS_INF_BITS    = 32'h7F800000;
    localparam logic [31:0] NEG_INF_BITS    = 32'hFF800000;
    localparam logic [31:0] MIN_NORMAL_BITS = 32'h00800000;
    localparam logic [24:0] CNT_FIELD_MAX   = 25'h1FFFFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [31:0] luminance_bits;
        logic        lum_valid;
        logic [31:0] min_bits;
        logic [31:0] max_bits;
        logic [24:0] invalid_count;
        logic        image_done;
    } result_t;

    // Classified luminance word passed from front to back
    typedef struct packed {
        logic        valid;
        logic [31:0] lum;
        logic        lum_ok;
        logic        last;
    } lum_word_t;

    // Leading zero count of a 48-bit word (48 when zero)
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Round to nearest even and pack. n has its leading one at bit 47, be is the
    // biased exponent. Returns {overflow, exponent and fraction}.
    function automatic logic [31:0] rnd_pack(input logic [47:0] n,
                                             input logic signed [10:0] be);
        logic signed [10:0] shs;
        logic [47:0]        s;
        logic               stk;
        logic [7:0]         ef;
        logic               inc;
        logic [31:0]        pk;
        logic               ovf;
        shs = '0;
        stk = 1'b0;
        if (be > 11'sd0) begin
            s  = n;
            ef = be[7:0];
        end else begin
            // subnormal: shift right so the exponent field becomes zero
            shs = 11'sd1 - be;
            ef  = '0;
            if (shs > 11'sd47) begin
                s   = '0;
                stk = |n;
            end else begin
                s   = n >> shs[5:0];
                stk = |(n & ~({48{1'b1}} << shs[5:0]));
            end
        end
        inc = s[23] & (stk | (|s[22:0]) | s[24]);
        pk  = {1'b0, ef, s[46:24]} + {31'b0, inc};
        ovf = (be > 11'sd254) || (pk[30:0] >= 31'h7F800000);
        return {ovf, pk[30:0]};
    endfunction

endpackage

`default_nettype wire

[sv/lvmm_fmul.sv]
// Three-stage float32 multiplier with a non-finite flag.
`timescale 1ns / 1ps
`default_nettype none

module lvmm_fmul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] prod,
    output logic             prod_sp
);
    import lvmm_pkg::*;

    logic [47:0]        p_reg;
    logic [8:0]         esum_reg;
    logic               sgn1_reg;
    logic               sp1_reg;
    logic [47:0]        n_reg;
    logic signed [10:0] be_reg;
    logic               sgn2_reg;
    logic               sp2_reg;
    logic               zero_reg;
    logic [31:0]        prod_reg;
    logic               psp_reg;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [5:0]  lz;
    logic [31:0] rp;

    assign ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    assign eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    assign ma = {a[30:23] != 8'd0, a[22:0]};
    assign mb = {b[30:23] != 8'd0, b[22:0]};
    assign lz = lzc48(p_reg);
    assign rp = rnd_pack(n_reg, be_reg);

    // Multiply significands, add exponents
    always_ff @(posedge clk)
    begin
        p_reg    <= ma * mb;
        esum_reg <= {1'b0, ea} + {1'b0, eb};
        sgn1_reg <= a[31] ^ b[31];
        sp1_reg  <= (a[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
    end

    // Normalize so the leading one sits at the top
    always_ff @(posedge clk)
    begin
        n_reg    <= p_reg << lz;
        be_reg   <= $signed({2'b00, esum_reg}) - 11'sd126 - $signed({5'b0, lz});
        sgn2_reg <= sgn1_reg;
        sp2_reg  <= sp1_reg;
        zero_reg <= (p_reg == 48'd0);
    end

    // Round and pack
    always_ff @(posedge clk)
    begin
        prod_reg <= zero_reg ? 32'd0 : {sgn2_reg, rp[30:0]};
        psp_reg  <= sp2_reg | (rp[31] & ~zero_reg);
    end

    assign prod    = prod_reg;
    assign prod_sp = psp_reg;

endmodule

`default_nettype wire

[sv/lvmm_fadd.sv]
// Three-stage float32 adder with a non-finite flag.
`timescale 1ns / 1ps
`default_nettype none

module lvmm_fadd (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic        a_sp,
    input  wire logic [31:0] b,
    input  wire logic        b_sp,
    output logic      [31:0] sum,
    output logic             sum_sp
);
    import lvmm_pkg::*;

    logic [26:0]        mx_reg;
    logic [26:0]        al_reg;
    logic [7:0]         ex_reg;
    logic               sgn1_reg;
    logic               sub_reg;
    logic               sp1_reg;
    logic [47:0]        n_reg;
    logic signed [10:0] be_reg;
    logic               sgn2_reg;
    logic               sp2_reg;
    logic               zero_reg;
    logic [31:0]        sum_reg;
    logic               ssp_reg;

    logic        swap;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] my_ext, al;
    logic [27:0] s;
    logic [5:0]  lz;
    logic [31:0] rp;

    // Order operands by magnitude and align the smaller one
    always_comb
    begin
        swap   = b[30:0] > a[30:0];
        x      = swap ? b : a;
        y      = swap ? a : b;
        ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d      = ex - ey;
        my_ext = {y[30:23] != 8'd0, y[22:0], 3'b000};
        if (d > 8'd26) begin
            al = {26'd0, |my_ext};
        end else begin
            al    = my_ext >> d[4:0];
            al[0] = al[0] | (|(my_ext & ~({27{1'b1}} << d[4:0])));
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= {x[30:23] != 8'd0, x[22:0], 3'b000};
        al_reg   <= al;
        ex_reg   <= ex;
        sgn1_reg <= x[31];
        sub_reg  <= x[31] ^ y[31];
        sp1_reg  <= a_sp | b_sp;
    end

    // Add or subtract, then normalize
    assign s  = sub_reg ? ({1'b0, mx_reg} - {1'b0, al_reg}) : ({1'b0, mx_reg} + {1'b0, al_reg});
    assign lz = lzc48({s, 20'd0});

    always_ff @(posedge clk)
    begin
        n_reg    <= {s << lz[4:0], 20'd0};
        be_reg   <= $signed({3'b000, ex_reg}) + 11'sd1 - $signed({5'b0, lz});
        sgn2_reg <= sgn1_reg;
        sp2_reg  <= sp1_reg;
        zero_reg <= (s == 28'd0);
    end

    // Round and pack
    assign rp = rnd_pack(n_reg, be_reg);

    always_ff @(posedge clk)
    begin
        sum_reg <= zero_reg ? 32'd0 : {sgn2_reg, rp[30:0]};
        ssp_reg <= sp2_reg | (rp[31] & ~zero_reg);
    end

    assign sum    = sum_reg;
    assign sum_sp = ssp_reg;

endmodule

`default_nettype wire

[sv/lvmm_front.sv]
// Front pipeline: weighted luminance sum and validity classification.
`timescale 1ns / 1ps
`default_nettype none

module lvmm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire lvmm_pkg::pixel_t    pixel,
    input  wire logic [31:0]         red_weight,
    input  wire logic [31:0]         green_weight,
    input  wire logic [31:0]         blue_weight,
    output lvmm_pkg::lum_word_t      word
);
    import lvmm_pkg::*;

    localparam int LAT = 9;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] last_reg;
    logic [31:0]    pbd_reg [3];
    logic [2:0]     pbsp_reg;

    logic [31:0] pr, pg, pb, s1, s2;
    logic        pr_sp, pg_sp, pb_sp, s1_sp, s2_sp;
    logic        ok;

    lvmm_fmul u_mul_r (.clk(clk), .a(pixel.red_bits), .b(red_weight), .prod(pr), .prod_sp(pr_sp));
    lvmm_fmul u_mul_g (.clk(clk), .a(pixel.green_bits), .b(green_weight),
                       .prod(pg), .prod_sp(pg_sp));
    lvmm_fmul u_mul_b (.clk(clk), .a(pixel.blue_bits), .b(blue_weight),
                       .prod(pb), .prod_sp(pb_sp));

    lvmm_fadd u_add_rg (.clk(clk), .a(pr), .a_sp(pr_sp), .b(pg), .b_sp(pg_sp),
                        .sum(s1), .sum_sp(s1_sp));
    lvmm_fadd u_add_b (.clk(clk), .a(s1), .a_sp(s1_sp), .b(pbd_reg[2]), .b_sp(pbsp_reg[2]),
                       .sum(s2), .sum_sp(s2_sp));

    // Delay the blue product to meet the first sum
    always_ff @(posedge clk)
    begin
        pbd_reg[0] <= pb;
        pbd_reg[1] <= pbd_reg[0];
        pbd_reg[2] <= pbd_reg[1];
        pbsp_reg   <= {pbsp_reg[1:0], pb_sp};
    end

    // Advance valid and end-of-image markers along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[LAT-2:0], pixel.last_pixel};
    end

    // Positive, normal and finite only
    assign ok = !s2_sp && (s2 >= MIN_NORMAL_BITS) && (s2 < POS_INF_BITS);

    assign word.valid  = vld_reg[LAT-1];
    assign word.lum    = ok ? s2 : 32'd0;
    assign word.lum_ok = ok;
    assign word.last   = last_reg[LAT-1];

endmodule

`default_nettype wire

[sv/lvmm_back.sv]
// Back end: luminance queue and running min, max and invalid count.
`timescale 1ns / 1ps
`default_nettype none

module lvmm_back #(
    parameter int          AW      = 4,
    parameter logic [24:0] CNT_CAP = 25'h1000000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lvmm_pkg::lum_word_t word,
    input  wire logic                pop,
    output logic                     empty,
    output lvmm_pkg::result_t        result,
    output logic [AW:0]              q_count
);
    import lvmm_pkg::*;

    localparam int DEPTH = 1 << AW;

    typedef struct packed {
        logic [31:0] lum;
        logic        lum_ok;
        logic        last;
    } entry_t;

    entry_t      mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   cnt_reg;
    logic [31:0]   min_reg, max_reg;
    logic [24:0]   bad_reg;
    entry_t        head_reg;

    entry_t        wr_entry;
    logic [AW-1:0] rd_ptr_next;
    logic          do_pop;
    logic [31:0]   min_next, max_next;
    logic [24:0]   bad_next;

    assign wr_entry    = '{lum: word.lum, lum_ok: word.lum_ok, last: word.last};
    assign empty       = (cnt_reg == '0);
    assign do_pop      = pop && !empty;
    assign rd_ptr_next = rd_ptr_reg + {{(AW-1){1'b0}}, do_pop};

    // Write incoming words; load the next head word, bypassing a same-slot write
    always_ff @(posedge clk)
    begin
        if (word.valid) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
        if (word.valid && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= wr_entry;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    // Statistics including the head word
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        bad_next = bad_reg;
        if (head_reg.lum_ok) begin
            if (head_reg.lum < min_reg) begin
                min_next = head_reg.lum;
            end
            if (max_reg == NEG_INF_BITS || head_reg.lum > max_reg) begin
                max_next = head_reg.lum;
            end
        end else if (bad_reg < CNT_CAP) begin
            bad_next = bad_reg + 25'd1;
        end
    end

    assign result.luminance_bits = head_reg.lum;
    assign result.lum_valid      = head_reg.lum_ok;
    assign result.min_bits       = min_next;
    assign result.max_bits       = max_next;
    assign result.invalid_count  = bad_next;
    assign result.image_done     = head_reg.last;
    assign q_count               = cnt_reg;

    // Advance pointers and commit or clear statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            min_reg    <= POS_INF_BITS;
            max_reg    <= NEG_INF_BITS;
            bad_reg    <= '0;
        end else begin
            if (word.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
                if (head_reg.last) begin
                    min_reg <= POS_INF_BITS;
                    max_reg <= NEG_INF_BITS;
                    bad_reg <= '0;
                end else begin
                    min_reg <= min_next;
                    max_reg <= max_next;
                    bad_reg <= bad_next;
                end
            end
            cnt_reg <= cnt_reg + {{AW{1'b0}}, word.valid} - {{AW{1'b0}}, do_pop};
        end
    end

endmodule

`default_nettype wire

[sv/luminance_validate_min_max_stats.sv]
// Top level: weight registers, credit control, front pipeline and back end.
// Usage:
//   Pixels enter as a pixel_t word through push/full; a word is taken at a
//   clock edge with push high and full low. Results leave as result_t words
//   through empty/pop; the head word is shown while empty is low and taken at
//   an edge with pop high.
//   An accepted pixel's result shows after three multiply stages, two
//   three-stage adders and one queue write.
//   Throughput: one pixel per cycle while results are popped; the credit
//   count of 2**QUEUE_AW words (accepted, not yet popped) sets full.
//   When the receiver stalls, words pile up in the queue and full rises
//   once the credit count is used up; nothing is dropped.
//   Weights are written on wr_en with wr_index 0..2 (red, green, blue) and
//   must be written only while idle. Reset restores the default weights,
//   empties the queue and sets min to +inf, max to -inf, the count to zero.
//   The statistics also return to those values after an image_done result.
`timescale 1ns / 1ps
`default_nettype none

module luminance_validate_min_max_stats #(
    parameter int unsigned MAX_PIXELS = 16777216,
    parameter int          QUEUE_AW   = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lvmm_pkg::pixel_t  pixel,
    input  wire logic              pop,
    output logic                   empty,
    output lvmm_pkg::result_t      result,
    input  wire logic              wr_en,
    input  wire logic [1:0]        wr_index,
    input  wire logic [31:0]       wr_data
);
    import lvmm_pkg::*;

    localparam int          DEPTH   = 1 << QUEUE_AW;
    localparam logic [24:0] CNT_CAP =
        (MAX_PIXELS > 32'h1FFFFFF) ? CNT_FIELD_MAX : 25'(MAX_PIXELS);

    logic [31:0]       red_weight_reg, green_weight_reg, blue_weight_reg;
    logic [QUEUE_AW:0] credit_reg;
    logic [QUEUE_AW:0] q_count;
    logic              accept, taken;
    lum_word_t         word;

    assign accept = push && !full;
    assign taken  = pop && !empty;
    assign full   = (credit_reg == (QUEUE_AW + 1)'(DEPTH));

    // Hold weight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            red_weight_reg   <= RED_WEIGHT_RST;
            green_weight_reg <= GREEN_WEIGHT_RST;
            blue_weight_reg  <= BLUE_WEIGHT_RST;
        end else if (wr_en) begin
            case (wr_index)
                REG_RED:   red_weight_reg   <= wr_data;
                REG_GREEN: green_weight_reg <= wr_data;
                REG_BLUE:  blue_weight_reg  <= wr_data;
                default:   ;
            endcase
        end
    end

    // Count words accepted and not yet popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_reg + {{QUEUE_AW{1'b0}}, accept}
                                     - {{QUEUE_AW{1'b0}}, taken};
        end
    end

    lvmm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (pixel),
        .red_weight   (red_weight_reg),
        .green_weight (green_weight_reg),
        .blue_weight  (blue_weight_reg),
        .word         (word)
    );

    lvmm_back #(
        .AW      (QUEUE_AW),
        .CNT_CAP (CNT_CAP)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .word    (word),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .q_count (q_count)
    );

    // Credits never exceed the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (QUEUE_AW + 1)'(DEPTH))
        else $error("credit count above queue depth");

    // Queued words are always covered by credits
    a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= credit_reg)
        else $error("queue holds more words than credited");

    // An accept without a pop takes one credit
    a_credit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !taken) |=> (credit_reg == $past(credit_reg) + 1'b1))
        else $error("credit not taken on accept");

endmodule

`default_nettype wire
